FILE: design/onewire_master_timing_defines.svh
// assertion macros shared by the one-wire master checker
// depends on nothing; the asserting module must have clk and arst_n in scope
`ifndef ONEWIRE_MASTER_TIMING_DEFINES_SVH
`define ONEWIRE_MASTER_TIMING_DEFINES_SVH

// same-cycle implication, held off during reset
`define OWMT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define OWMT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/owmt_pkg.sv
// types, constants and helper functions for the one-wire bus master
// used by onewire_master_timing; depends on nothing
package owmt_pkg;

	// fixed timings in microseconds
	localparam logic [9:0] READ_TAIL_US     = 10'd50;
	localparam logic [9:0] BIT_GAP_US       = 10'd1;
	localparam logic [9:0] RESET_RELEASE_US = 10'd10;

	localparam int NUM_REGS   = 8;
	localparam int REG_W      = 10;
	localparam int ADDR_W     = 5;
	localparam int S_DATA_W   = 16;
	localparam int S_USER_W   = 2;
	localparam int M_DATA_W   = 16;

	// request kinds carried on tuser
	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_RESET = 2'd1,
		REQ_WRITE = 2'd2,
		REQ_READ  = 2'd3
	} req_t;

	// register map indexes
	typedef enum logic [2:0] {
		REG_RESET_LOW      = 3'd0,
		REG_PRESENCE_WIN   = 3'd1,
		REG_WR_ONE_LOW     = 3'd2,
		REG_WR_ONE_REL     = 3'd3,
		REG_WR_ZERO_LOW    = 3'd4,
		REG_WR_ZERO_REL    = 3'd5,
		REG_READ_LOW       = 3'd6,
		REG_READ_WIN       = 3'd7
	} reg_idx_t;

	typedef logic [REG_W-1:0] cfg_arr_t [NUM_REGS];

	localparam cfg_arr_t CFG_RESET = '{
		10'd480, 10'd480, 10'd6, 10'd64, 10'd60, 10'd10, 10'd6, 10'd15
	};

	// sequencer phases, one-hot
	typedef enum logic [10:0] {
		PH_IDLE       = 11'b000_0000_0001,
		PH_RST_LOW    = 11'b000_0000_0010,
		PH_RST_REL    = 11'b000_0000_0100,
		PH_RST_SAMPLE = 11'b000_0000_1000,
		PH_RST_GUARD  = 11'b000_0001_0000,
		PH_GAP        = 11'b000_0010_0000,
		PH_WR_LOW     = 11'b000_0100_0000,
		PH_WR_REL     = 11'b000_1000_0000,
		PH_RD_LOW     = 11'b001_0000_0000,
		PH_RD_SAMPLE  = 11'b010_0000_0000,
		PH_RD_TAIL    = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		phase_t            phase;
		logic [REG_W-1:0]  tc;
	} slot_t;

	// a zero duration counts as one microsecond
	function automatic logic [REG_W-1:0] dur(input logic [REG_W-1:0] v);
		return (v == '0) ? REG_W'(1) : v;
	endfunction

	// low phase that opens a write or read slot
	function automatic slot_t slot_start(input req_t op, input logic [7:0] shift,
			input logic [REG_W-1:0] one_low, input logic [REG_W-1:0] zero_low,
			input logic [REG_W-1:0] rd_low);
		slot_t s;
		if (op == REQ_WRITE) begin
			s.phase = PH_WR_LOW;
			s.tc    = dur(shift[0] ? one_low : zero_low);
		end else begin
			s.phase = PH_RD_LOW;
			s.tc    = dur(rd_low);
		end
		return s;
	endfunction

	// gap before each bit, skipped when the gap is zero
	function automatic slot_t bit_start(input req_t op, input logic [7:0] shift,
			input logic [REG_W-1:0] one_low, input logic [REG_W-1:0] zero_low,
			input logic [REG_W-1:0] rd_low);
		slot_t s;
		if (BIT_GAP_US != '0) begin
			s.phase = PH_GAP;
			s.tc    = dur(BIT_GAP_US);
		end else begin
			s = slot_start(op, shift, one_low, zero_low, rd_low);
		end
		return s;
	endfunction

endpackage

FILE: design/onewire_master_timing.sv
// one-wire bus master timing sequencer, paced by microsecond tick words
// depends on owmt_pkg
//
//  channel  dir  handshake                 payload
//  s        in   s_tvalid / s_tready       tuser: req_type; tdata: data_byte, line_level
//  m        out  m_tvalid / m_tready       tdata: drive_low .. cmd_rejected
//  cfg      in   psel / penable / pready   apb, 8 timing registers at 4*i
//
// one word in and one word out per cycle while m_tready is high; each word passes the input register,
// then the sequencer update into the result register
// all timing counts live in a single 10 bit down counter decremented per tick word
// reset: sequencer idle, timing registers at their default values, no clearing pass
// s_tready only drops when both the input and the result register hold a word
// and m_tready is low
module onewire_master_timing (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [7:0] data_byte, [8] line_level, [15:9] zero
	input  logic [owmt_pkg::S_DATA_W-1:0]      s_tdata,
	// [1:0] req_type
	input  logic [owmt_pkg::S_USER_W-1:0]      s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [0] drive_low, [1] busy_res, [2] done_res, [3] no_device,
	// [11:4] read_data, [12] cmd_rejected, [15:13] zero
	output logic [owmt_pkg::M_DATA_W-1:0]      m_tdata,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [owmt_pkg::ADDR_W-1:0]        paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	localparam int W = owmt_pkg::REG_W;

	owmt_pkg::cfg_arr_t  cfg_q;

	logic                in_valid_s1;
	owmt_pkg::req_t      req_s1;
	logic [7:0]          data_s1;
	logic                line_s1;

	owmt_pkg::phase_t    phase_q;
	owmt_pkg::req_t      op_q;
	logic [W-1:0]        tc_q;
	logic [2:0]          bit_q;
	logic [7:0]          shift_q;
	logic                low_q;

	logic                out_valid_q;
	logic [owmt_pkg::M_DATA_W-1:0] out_q;

	owmt_pkg::phase_t    n_phase;
	owmt_pkg::req_t      n_op;
	logic [W-1:0]        n_tc;
	logic [2:0]          n_bit;
	logic [7:0]          n_shift;
	logic                n_low;
	logic                n_done;
	logic                n_rej;
	logic                end_bit;
	owmt_pkg::slot_t     sl;
	logic                busy;
	logic                n_busy;
	logic                adv;
	logic                fire;
	logic                cfg_wr;

	// apb register file
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = {{(32 - W){1'b0}}, cfg_q[paddr[4:2]]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= owmt_pkg::CFG_RESET;
		end else if (cfg_wr) begin
			cfg_q[paddr[4:2]] <= pwdata[W-1:0];
		end
	end

	// stream handshake
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !in_valid_s1 || adv;
	assign fire     = in_valid_s1 && adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1  <= owmt_pkg::req_t'(s_tuser[1:0]);
			data_s1 <= s_tdata[7:0];
			line_s1 <= s_tdata[8];
		end
	end

	assign busy = (phase_q != owmt_pkg::PH_IDLE);

	// sequencer next state for one word
	always_comb begin
		n_phase = phase_q;
		n_op    = op_q;
		n_tc    = tc_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_low   = low_q;
		n_done  = 1'b0;
		n_rej   = 1'b0;
		end_bit = 1'b0;
		sl      = '{phase: owmt_pkg::PH_IDLE, tc: '0};
		if (req_s1 != owmt_pkg::REQ_TICK) begin
			if (busy) begin
				n_rej = 1'b1;
			end else begin
				n_op  = req_s1;
				n_bit = '0;
				n_low = 1'b0;
				if (req_s1 == owmt_pkg::REQ_RESET) begin
					n_shift = '0;
					n_phase = owmt_pkg::PH_RST_LOW;
					n_tc    = owmt_pkg::dur(cfg_q[owmt_pkg::REG_RESET_LOW]);
				end else begin
					n_shift = (req_s1 == owmt_pkg::REQ_WRITE) ? data_s1 : 8'd0;
					sl = owmt_pkg::bit_start(req_s1, n_shift,
						cfg_q[owmt_pkg::REG_WR_ONE_LOW], cfg_q[owmt_pkg::REG_WR_ZERO_LOW],
						cfg_q[owmt_pkg::REG_READ_LOW]);
					n_phase = sl.phase;
					n_tc    = sl.tc;
				end
			end
		end else if (busy) begin
			// any low sample inside a window counts
			if ((phase_q == owmt_pkg::PH_RST_SAMPLE || phase_q == owmt_pkg::PH_RD_SAMPLE)
					&& !line_s1) begin
				n_low = 1'b1;
			end
			if (tc_q > W'(1)) begin
				n_tc = tc_q - W'(1);
			end else begin
				unique case (phase_q)
					owmt_pkg::PH_RST_LOW: begin
						n_phase = owmt_pkg::PH_RST_REL;
						n_tc    = owmt_pkg::dur(owmt_pkg::RESET_RELEASE_US);
					end
					owmt_pkg::PH_RST_REL: begin
						n_low   = 1'b0;
						n_phase = owmt_pkg::PH_RST_SAMPLE;
						n_tc    = owmt_pkg::dur(cfg_q[owmt_pkg::REG_PRESENCE_WIN]);
					end
					owmt_pkg::PH_RST_SAMPLE: begin
						n_phase = owmt_pkg::PH_RST_GUARD;
						n_tc    = owmt_pkg::dur(owmt_pkg::RESET_RELEASE_US);
					end
					owmt_pkg::PH_RST_GUARD: begin
						n_phase = owmt_pkg::PH_IDLE;
						n_tc    = '0;
						n_done  = 1'b1;
					end
					owmt_pkg::PH_GAP: begin
						sl = owmt_pkg::slot_start(op_q, shift_q,
							cfg_q[owmt_pkg::REG_WR_ONE_LOW], cfg_q[owmt_pkg::REG_WR_ZERO_LOW],
							cfg_q[owmt_pkg::REG_READ_LOW]);
						n_phase = sl.phase;
						n_tc    = sl.tc;
					end
					owmt_pkg::PH_WR_LOW: begin
						n_phase = owmt_pkg::PH_WR_REL;
						n_tc    = owmt_pkg::dur(shift_q[0] ? cfg_q[owmt_pkg::REG_WR_ONE_REL]
							: cfg_q[owmt_pkg::REG_WR_ZERO_REL]);
					end
					owmt_pkg::PH_WR_REL: begin
						n_shift = {1'b0, shift_q[7:1]};
						end_bit = 1'b1;
					end
					owmt_pkg::PH_RD_LOW: begin
						n_low   = 1'b0;
						n_phase = owmt_pkg::PH_RD_SAMPLE;
						n_tc    = owmt_pkg::dur(cfg_q[owmt_pkg::REG_READ_WIN]);
					end
					owmt_pkg::PH_RD_SAMPLE: begin
						n_shift = {~n_low, shift_q[7:1]};
						n_phase = owmt_pkg::PH_RD_TAIL;
						n_tc    = owmt_pkg::dur(owmt_pkg::READ_TAIL_US);
					end
					owmt_pkg::PH_RD_TAIL: begin
						end_bit = 1'b1;
					end
					default: begin
						n_phase = owmt_pkg::PH_IDLE;
						n_tc    = '0;
					end
				endcase
				// close a bit slot: finish after the eighth, else start the next
				if (end_bit) begin
					if (bit_q == 3'd7) begin
						n_phase = owmt_pkg::PH_IDLE;
						n_tc    = '0;
						n_done  = 1'b1;
					end else begin
						n_bit = bit_q + 3'd1;
						sl = owmt_pkg::bit_start(op_q, n_shift,
							cfg_q[owmt_pkg::REG_WR_ONE_LOW], cfg_q[owmt_pkg::REG_WR_ZERO_LOW],
							cfg_q[owmt_pkg::REG_READ_LOW]);
						n_phase = sl.phase;
						n_tc    = sl.tc;
					end
				end
			end
		end
	end

	assign n_busy = (n_phase != owmt_pkg::PH_IDLE);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= owmt_pkg::PH_IDLE;
			op_q    <= owmt_pkg::REQ_TICK;
			tc_q    <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			low_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= n_phase;
			op_q    <= n_op;
			tc_q    <= n_tc;
			bit_q   <= n_bit;
			shift_q <= n_shift;
			low_q   <= n_low;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= {3'b000,
				n_rej,
				(!n_busy && n_op == owmt_pkg::REQ_READ) ? n_shift : 8'd0,
				!n_busy && n_op == owmt_pkg::REQ_RESET && !n_low,
				n_done,
				n_busy,
				n_phase == owmt_pkg::PH_RST_LOW || n_phase == owmt_pkg::PH_WR_LOW
					|| n_phase == owmt_pkg::PH_RD_LOW};
		end
	end

endmodule

FILE: design/owmt_checker.sv
// port-level checks for the one-wire bus master, bound to the top level
// depends on onewire_master_timing_defines.svh and onewire_master_timing
`include "onewire_master_timing_defines.svh"

module owmt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// a stalled result word holds
	`OWMT_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

	// the bus is only driven inside a sequence
	`OWMT_ASSERT_NOW(a_drive_busy, m_tvalid && m_tdata[0], m_tdata[1], "drive_low outside a sequence")

	// a finished sequence leaves the block idle
	`OWMT_ASSERT_NOW(a_done_idle, m_tvalid && m_tdata[2], !m_tdata[1], "done while still busy")

	// rejection only happens during a sequence, which carries on
	`OWMT_ASSERT_NOW(a_rej_busy, m_tvalid && m_tdata[12], m_tdata[1], "command rejected while idle")

	// presence and read results never show together
	`OWMT_ASSERT_NOW(a_nodev_data, m_tvalid && m_tdata[3], m_tdata[11:4] == 8'd0, "no_device with read data")

endmodule

bind onewire_master_timing owmt_checker u_owmt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
